// ----- rtl/core/ucp_pkg.sv -----
// ucp_pkg: shared types and constants for the serial clock command parser.
// Used by ucp_ctrl, ucp_datapath and uart_clock_command_parser. No dependencies.
package ucp_pkg;

  localparam logic [7:0] CH_START = 8'h26;  // '&'
  localparam logic [7:0] CH_END   = 8'h2E;  // '.'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

  // command characters at frame position 1
  localparam logic [7:0] CH_CMD_LIGHT   = 8'h31;
  localparam logic [7:0] CH_CMD_TIME    = 8'h32;
  localparam logic [7:0] CH_CMD_DISPLAY = 8'h33;
  localparam logic [7:0] CH_CMD_COUNT   = 8'h34;
  localparam logic [7:0] CH_CMD_AUTOOFF = 8'h35;
  localparam logic [7:0] CH_CMD_ALARM   = 8'h37;

  // display clamp thresholds, as characters
  localparam logic [7:0] CH_TWO  = 8'h32;
  localparam logic [7:0] CH_FOUR = 8'h34;

  localparam int OUT_W = 56;  // packed result width, whole bytes

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_LIGHT   = 3'd1,
    CMD_TIME    = 3'd2,
    CMD_DISPLAY = 3'd3,
    CMD_COUNT   = 3'd4,
    CMD_AUTOOFF = 3'd5,
    CMD_ALARM   = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ECHO
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // store the incoming byte
    logic decode;  // decode the finished frame
    logic load;    // load next echo result into the output register
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic byte_end;   // incoming byte is the terminator
    logic echo_last;  // next echo result is the final one
    logic out_free;   // output register can take a result
  } status_t;

endpackage

// ----- rtl/core/ucp_ctrl.sv -----
// ucp_ctrl: sequencing state machine for the command parser.
// Depends on ucp_pkg; drives ucp_datapath through ctrl_t, reads status_t.
module ucp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  ucp_pkg::status_t status,
  output ucp_pkg::ctrl_t   ctrl
);

  ucp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ucp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    ctrl.accept = 1'b0;
    ctrl.decode = 1'b0;
    ctrl.load   = 1'b0;
    unique case (state)
      ucp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.accept = 1'b1;
          if (status.byte_end) state_next = ucp_pkg::ST_DECODE;
        end
      end
      ucp_pkg::ST_DECODE: begin
        ctrl.decode = 1'b1;
        state_next  = ucp_pkg::ST_ECHO;
      end
      ucp_pkg::ST_ECHO: begin
        if (status.out_free) begin
          ctrl.load = 1'b1;
          if (status.echo_last) state_next = ucp_pkg::ST_IDLE;
        end
      end
      default: state_next = ucp_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/ucp_datapath.sv -----
// ucp_datapath: frame store, command decode, settings registers and output register.
// Depends on ucp_pkg; controlled by ucp_ctrl.
module ucp_datapath #(
  parameter int FRAME_LEN = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ucp_pkg::ctrl_t             ctrl,
  output ucp_pkg::status_t           status,
  input  logic [7:0]                 s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [ucp_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tlast
);

  localparam int AW = $clog2(FRAME_LEN);
  localparam int IW = $clog2(FRAME_LEN + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(FRAME_LEN - 1);

  logic [7:0]    frame [FRAME_LEN];
  logic [7:0]    padded [FRAME_LEN];
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] base_idx;
  logic [IW-1:0] rd_inc;

  logic [7:0]    light_reg, display_reg, auto_off_reg;
  ucp_pkg::cmd_t cmd_reg;
  logic [7:0]    hour_reg, minute_reg;

  logic [7:0]    d3, d4, d6, d7, hour_calc, minute_calc, echo_byte;

  // positions at or past the count read as terminator padding
  always_comb begin
    for (int i = 0; i < FRAME_LEN; i++) begin
      padded[i] = (IW'(i) < wr_idx) ? frame[i] : ucp_pkg::CH_END;
    end
  end

  assign d3          = padded[3] - ucp_pkg::CH_ZERO;
  assign d4          = padded[4] - ucp_pkg::CH_ZERO;
  assign d6          = padded[6] - ucp_pkg::CH_ZERO;
  assign d7          = padded[7] - ucp_pkg::CH_ZERO;
  assign hour_calc   = d3 * 8'd10 + d4;
  assign minute_calc = d6 * 8'd10 + d7;

  assign base_idx = (s_tdata == ucp_pkg::CH_START || wr_idx > LAST_POS) ? '0 : wr_idx;
  assign rd_inc   = rd_idx + 1'b1;
  assign echo_byte = padded[rd_idx[AW-1:0]];

  assign status.byte_end  = (s_tdata == ucp_pkg::CH_END);
  assign status.echo_last = (rd_inc == wr_idx);
  assign status.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (ctrl.accept) frame[base_idx[AW-1:0]] <= s_tdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx       <= '0;
      rd_idx       <= '0;
      light_reg    <= 8'd1;
      display_reg  <= 8'd0;
      auto_off_reg <= 8'd0;
    end else begin
      if (ctrl.accept) wr_idx <= base_idx + 1'b1;
      if (ctrl.decode) begin
        rd_idx <= '0;
        unique case (padded[1])
          ucp_pkg::CH_CMD_LIGHT:   light_reg <= d3;
          ucp_pkg::CH_CMD_DISPLAY: begin
            if (display_reg == 8'd0) begin
              display_reg <= (padded[3] < ucp_pkg::CH_TWO) ? d3 : 8'd1;
            end else begin
              display_reg <= (padded[3] < ucp_pkg::CH_FOUR) ? d3 : 8'd0;
            end
          end
          ucp_pkg::CH_CMD_COUNT:   display_reg <= 8'd1;
          ucp_pkg::CH_CMD_AUTOOFF: auto_off_reg <= d3;
          default: ;
        endcase
      end
      if (ctrl.load) begin
        rd_idx <= rd_inc;
        if (status.echo_last) wr_idx <= '0;
      end
    end
  end

  // command code and reported time, captured at decode
  always_ff @(posedge clk) begin
    if (ctrl.decode) begin
      hour_reg   <= 8'd0;
      minute_reg <= 8'd0;
      unique case (padded[1])
        ucp_pkg::CH_CMD_LIGHT:   cmd_reg <= ucp_pkg::CMD_LIGHT;
        ucp_pkg::CH_CMD_DISPLAY: cmd_reg <= ucp_pkg::CMD_DISPLAY;
        ucp_pkg::CH_CMD_AUTOOFF: cmd_reg <= ucp_pkg::CMD_AUTOOFF;
        ucp_pkg::CH_CMD_TIME: begin
          cmd_reg    <= ucp_pkg::CMD_TIME;
          hour_reg   <= hour_calc;
          minute_reg <= minute_calc;
        end
        ucp_pkg::CH_CMD_COUNT: begin
          cmd_reg    <= ucp_pkg::CMD_COUNT;
          hour_reg   <= hour_calc;
          minute_reg <= minute_calc;
        end
        ucp_pkg::CH_CMD_ALARM: begin
          cmd_reg    <= ucp_pkg::CMD_ALARM;
          hour_reg   <= hour_calc;
          minute_reg <= minute_calc;
        end
        default: cmd_reg <= ucp_pkg::CMD_NONE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      m_tlast <= status.echo_last;
      if (status.echo_last) begin
        m_tdata <= {5'd0, minute_reg, hour_reg, auto_off_reg, display_reg,
                    light_reg, cmd_reg, echo_byte};
      end else begin
        m_tdata <= {48'd0, echo_byte};
      end
    end
  end

endmodule

// ----- rtl/core/uart_clock_command_parser.sv -----
// uart_clock_command_parser: top level of the serial clock command parser.
// Depends on ucp_pkg, ucp_ctrl and ucp_datapath.
//
// Each received byte is stored in the frame store; '&' restarts the frame and an
// overlong frame wraps to position 0. On the '.' terminator the block leaves idle,
// decodes the command at position 1 in the decode state, then in the echo state
// sends the frame bytes back one per cycle while the output register is free, the
// command fields on the last one (m_tlast). No new byte is taken (s_tready low)
// until all N bytes have been echoed, N the frame length so far (at most
// FRAME_LEN), read through the single echo read port of the frame store. Settings
// reset to light 1, display 0, auto-off 0. The final echo result may wait in the
// output register while the next byte is taken.
module uart_clock_command_parser #(
  parameter int FRAME_LEN = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [7:0] echo_byte, [10:8] command, [18:11] light_on, [26:19] display_mode,
  // [34:27] auto_off, [42:35] hour_value, [50:43] minute_value, [55:51] zero
  output logic [ucp_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tlast    // last_of_run
);

  ucp_pkg::ctrl_t   ctrl;
  ucp_pkg::status_t status;

  ucp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  ucp_datapath #(
    .FRAME_LEN (FRAME_LEN)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- verif/uart_clock_command_parser_tb.sv -----
// uart_clock_command_parser_tb: self-checking bench for the serial clock command parser.
// Needs ucp_pkg and uart_clock_command_parser. Directed frames first, then random
// frames and noise, with random stalls on both streams.
module uart_clock_command_parser_tb;

  localparam int FRAME_LEN      = 11;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_BYTES   = 400;
  localparam int DIR_ROWS       = 24;
  localparam logic [7:0] CH_SIX = 8'h36;  // unused command digit

  // one echo result as it should appear on the master stream
  typedef struct packed {
    logic [7:0]     echo;
    logic           last;
    ucp_pkg::cmd_t  cmd;
    logic [7:0]     light;
    logic [7:0]     disp;
    logic [7:0]     aoff;
    logic [7:0]     hour;
    logic [7:0]     minute;
  } echo_t;

  // stimulus row; when typed is set, the final echo of this request carries these fields
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic [2:0] cmd;
    logic [7:0] light;
    logic [7:0] disp;
    logic [7:0] aoff;
    logic [7:0] hour;
    logic [7:0] minute;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [7:0]                   s_tdata = 8'h00;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [ucp_pkg::OUT_W-1:0]    m_tdata;
  logic                         m_tlast;

  stim_row_t row_cur = '0;
  bit        calm = 1'b0;
  bit        hold_go = 1'b0;
  bit        hold_fired = 1'b0;
  int        errors = 0;
  int        quiet_cycles = 0;
  int        bytes_sent = 0;
  int        results_checked = 0;
  int        frames_echoed = 0;
  int        cmd_count [0:6];

  // predictor state
  logic [7:0] frame_copy [0:FRAME_LEN-1];
  int         fill_pos;
  logic [7:0] light_set;
  logic [7:0] disp_set;
  logic [7:0] auto_off_set;
  echo_t      echo_due [$];

  stim_row_t dir_rows [0:DIR_ROWS-1] = '{
    // first frame after reset: unused command digit, settings at reset values
    '{ucp_pkg::CH_START, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{CH_SIX, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_END, 1'b1, ucp_pkg::CMD_NONE, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
    // light from a 0x00 digit wraps to 0xD0
    '{ucp_pkg::CH_START, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_CMD_LIGHT, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_END, 1'b1, ucp_pkg::CMD_LIGHT, 8'hD0, 8'h00, 8'h00, 8'h00, 8'h00},
    // short frames: digit positions come from the '.' padding
    '{ucp_pkg::CH_START, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_CMD_AUTOOFF, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_END, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // lone terminator at position 0
    '{ucp_pkg::CH_END, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    // display from state 0 with a negative digit
    '{ucp_pkg::CH_START, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_CMD_DISPLAY, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_END, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_START, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_CMD_COUNT, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_END, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_START, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_CMD_TIME, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_END, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_START, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_CMD_ALARM, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{ucp_pkg::CH_END, 1'b0, ucp_pkg::CMD_NONE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  uart_clock_command_parser #(
    .FRAME_LEN(FRAME_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [7:0] digit_of(input int pos);
    return frame_copy[pos] - ucp_pkg::CH_ZERO;
  endfunction

  function automatic logic [7:0] pair_of(input int pos);
    logic [7:0] t;
    t = digit_of(pos) * 8'd10 + digit_of(pos + 1);
    return t;
  endfunction

  task automatic clear_settings();
    for (int i = 0; i < FRAME_LEN; i++) frame_copy[i] = 8'h00;
    fill_pos     = 0;
    light_set    = 8'h01;
    disp_set     = 8'h00;
    auto_off_set = 8'h00;
    echo_due     = {};
  endtask

  task automatic parse_rx(input logic [7:0] b);
    int            n;
    int            v;
    ucp_pkg::cmd_t c;
    logic [7:0]    hr;
    logic [7:0]    mn;
    echo_t         e;
    if (b == ucp_pkg::CH_START || fill_pos > FRAME_LEN - 1) fill_pos = 0;
    frame_copy[fill_pos] = b;
    fill_pos++;
    if (b != ucp_pkg::CH_END) return;
    for (n = fill_pos; n < FRAME_LEN; n++) frame_copy[n] = ucp_pkg::CH_END;
    c  = ucp_pkg::CMD_NONE;
    hr = 8'h00;
    mn = 8'h00;
    case (frame_copy[1])
      ucp_pkg::CH_CMD_LIGHT: begin
        c = ucp_pkg::CMD_LIGHT;
        light_set = digit_of(3);
      end
      ucp_pkg::CH_CMD_TIME: begin
        c  = ucp_pkg::CMD_TIME;
        hr = pair_of(3);
        mn = pair_of(6);
      end
      ucp_pkg::CH_CMD_DISPLAY: begin
        c = ucp_pkg::CMD_DISPLAY;
        v = int'(frame_copy[3]) - int'(ucp_pkg::CH_ZERO);
        // clamp depends on the current mode
        if (disp_set == 8'h00) v = (v < 2) ? v : 1;
        else v = (v < 4) ? v : 0;
        disp_set = v[7:0];
      end
      ucp_pkg::CH_CMD_COUNT: begin
        c  = ucp_pkg::CMD_COUNT;
        hr = pair_of(3);
        mn = pair_of(6);
        disp_set = 8'h01;
      end
      ucp_pkg::CH_CMD_AUTOOFF: begin
        c = ucp_pkg::CMD_AUTOOFF;
        auto_off_set = digit_of(3);
      end
      ucp_pkg::CH_CMD_ALARM: begin
        c  = ucp_pkg::CMD_ALARM;
        hr = pair_of(3);
        mn = pair_of(6);
      end
      default: c = ucp_pkg::CMD_NONE;
    endcase
    for (n = 0; n < fill_pos; n++) begin
      e = '0;
      e.echo = frame_copy[n];
      if (n == fill_pos - 1) begin
        e.last   = 1'b1;
        e.cmd    = c;
        e.light  = light_set;
        e.disp   = disp_set;
        e.aoff   = auto_off_set;
        e.hour   = hr;
        e.minute = mn;
      end
      echo_due.push_back(e);
    end
    fill_pos = 0;
  endtask

  // ---------------------------------------------------------------- checking
  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
    end
  endtask

  task automatic check_echo();
    echo_t want;
    if (echo_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected echo, expected nothing, actual %014h last %0b",
               $time, m_tdata, m_tlast);
      return;
    end
    want = echo_due.pop_front();
    results_checked++;
    cmp_field("echo_byte", want.echo, m_tdata[7:0]);
    cmp_field("last_of_run", want.last, m_tlast);
    cmp_field("command", want.cmd, m_tdata[10:8]);
    cmp_field("light_on", want.light, m_tdata[18:11]);
    cmp_field("display_mode", want.disp, m_tdata[26:19]);
    cmp_field("auto_off", want.aoff, m_tdata[34:27]);
    cmp_field("hour_value", want.hour, m_tdata[42:35]);
    cmp_field("minute_value", want.minute, m_tdata[50:43]);
    cmp_field("pad bits", 8'h00, m_tdata[55:51]);
    if (want.last) begin
      frames_echoed++;
      cmd_count[want.cmd]++;
    end
  endtask

  task automatic apply_typed();
    echo_t e;
    e = echo_due.pop_back();
    e.cmd    = ucp_pkg::cmd_t'(row_cur.cmd);
    e.light  = row_cur.light;
    e.disp   = row_cur.disp;
    e.aoff   = row_cur.aoff;
    e.hour   = row_cur.hour;
    e.minute = row_cur.minute;
    echo_due.push_back(e);
  endtask

  // outputs checked before the input is predicted; a result never leaves on its own request edge
  always @(posedge clk) begin
    if (rst) begin
      clear_settings();
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) check_echo();
      if (s_tvalid && s_tready) begin
        parse_rx(s_tdata);
        if (row_cur.typed && s_tdata == ucp_pkg::CH_END) apply_typed();
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: watchdog, no request moved for %0d cycles, %0d echoes outstanding",
             $time, WATCHDOG_LIMIT, echo_due.size());
    $display("uart_clock_command_parser_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_row(input stim_row_t r);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 18) gap++;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= r.rx;
    row_cur  <= r;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    calm = (bytes_sent >= 180 && bytes_sent < 280);
    if (!hold_fired && bytes_sent >= 100) begin
      hold_fired = 1'b1;
      hold_go    = 1'b1;
    end
  endtask

  task automatic send_rx(input logic [7:0] b);
    stim_row_t r;
    r    = '0;
    r.rx = b;
    send_row(r);
  endtask

  function automatic logic [7:0] field_byte();
    if ($urandom_range(99) < 85) return ucp_pkg::CH_ZERO + 8'($urandom_range(9));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_frame();
    logic [7:0] c;
    int         len;
    if ($urandom_range(9) != 0) send_rx(ucp_pkg::CH_START);
    case ($urandom_range(8))
      0: c = ucp_pkg::CH_CMD_LIGHT;
      1: c = ucp_pkg::CH_CMD_TIME;
      2: c = ucp_pkg::CH_CMD_DISPLAY;
      3: c = ucp_pkg::CH_CMD_COUNT;
      4: c = ucp_pkg::CH_CMD_AUTOOFF;
      5: c = ucp_pkg::CH_CMD_ALARM;
      6: c = CH_SIX;
      7: c = ucp_pkg::CH_ZERO + 8'($urandom_range(9));
      default: c = 8'($urandom_range(255));
    endcase
    send_rx(c);
    // mostly full-length frames so hour and minute come from real digits
    len = ($urandom_range(3) == 0) ? $urandom_range(0, 9) : $urandom_range(7, 9);
    repeat (len) send_rx(field_byte());
    send_rx(ucp_pkg::CH_END);
  endtask

  initial begin
    int kind;
    for (int i = 0; i <= 6; i++) cmd_count[i] = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) send_row(dir_rows[i]);

    while (bytes_sent < DIR_ROWS + RANDOM_BYTES) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        send_frame();
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(255)));
      end else if (kind < 93) begin
        // overlong run: the index wraps back to position 0
        send_rx(ucp_pkg::CH_START);
        repeat ($urandom_range(11, 14)) send_rx(field_byte());
      end else begin
        // abandoned frame, restarted by the next '&'
        send_rx(ucp_pkg::CH_START);
        send_rx(ucp_pkg::CH_CMD_LIGHT + 8'($urandom_range(6)));
        repeat ($urandom_range(1, 5)) send_rx(field_byte());
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (echo_due.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d bytes in, %0d frames echoed as %0d results, one long output stall",
             bytes_sent, frames_echoed, results_checked);
    $display("commands: none %0d light %0d time %0d display %0d countdown %0d auto-off %0d alarm %0d",
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4],
             cmd_count[5], cmd_count[6]);
    if (errors == 0) begin
      $display("uart_clock_command_parser_tb: done, clean");
    end else begin
      $display("uart_clock_command_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
